FILE: sv/tcd_pkg.sv
`default_nettype none

package tcd_pkg;

  localparam int unsigned NumberWidthDef = 21;
  localparam int unsigned DepthWidth     = 5;
  localparam logic [DepthWidth-1:0] DepthMax = '1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_DIV_REST,
    ST_DIV_ACC,
    ST_DIV_LEFT,
    ST_STEP,
    ST_DONE
  } tcd_state_e;

endpackage

`default_nettype wire

FILE: sv/totient_and_chain_depth_top.sv
`default_nettype none

// Computes the Euler totient of number_i and the count of totient steps that take it down to 1.
// A word is taken when start_i is high while busy_o is low.
// The result is held on totient_o and chain_depth_o, marked by done_o for exactly one cycle.
// The receiver cannot stall the block.
// Each totient is found by trial division with every divisor from 2 up to the square root of the
// remaining cofactor. All divisions run through one restoring divider that retires one quotient
// bit per cycle. A trial divisor that divides the cofactor is divided out of it; on its first
// success the running totient is also divided by it and reduced by that quotient. A leftover prime
// factor reduces the running totient the same way, and each chain step restarts the search on the
// new totient. Inputs 0 and 1 skip the search and go straight to the result.
module totient_and_chain_depth_top
  import tcd_pkg::*;
#(
  parameter int unsigned NUMBER_WIDTH = NumberWidthDef
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    start_i,
  output logic                         busy_o,
  input  wire logic [NUMBER_WIDTH-1:0] number_i,
  output logic                         done_o,
  output logic [NUMBER_WIDTH-1:0]      totient_o,
  output logic [DepthWidth-1:0]        chain_depth_o
);

  localparam int unsigned W    = NUMBER_WIDTH;
  localparam int unsigned CntW = $clog2(W);
  localparam int unsigned SqW  = W + 2;

  tcd_state_e state_q, state_d;

  logic [W-1:0]          acc_q, acc_d;
  logic [W-1:0]          rest_q, rest_d;
  logic [W-1:0]          dv_q, dv_d;
  logic [SqW-1:0]        dsq_q, dsq_d;
  logic                  found_q, found_d;
  logic                  first_q, first_d;
  logic [W-1:0]          tot_q, tot_d;
  logic [DepthWidth-1:0] depth_q, depth_d;

  logic [W-1:0]    rem_q, rem_d;
  logic [W-1:0]    quo_q, quo_d;
  logic [W-1:0]    dvs_q, dvs_d;
  logic [CntW-1:0] cnt_q, cnt_d;

  logic [W:0]   trial;
  logic [W:0]   diff;
  logic         fits;
  logic [W-1:0] rem_nx;
  logic [W-1:0] quo_nx;
  logic         div_last;
  logic         sq_in;
  logic         rest_gt1;
  logic         acc_gt1;

  // One step of the shared restoring divider.
  assign trial  = {rem_q, quo_q[W-1]};
  assign diff   = trial - {1'b0, dvs_q};
  assign fits   = ~diff[W];
  assign rem_nx = fits ? diff[W-1:0] : trial[W-1:0];
  assign quo_nx = {quo_q[W-2:0], fits};

  assign div_last = (cnt_q == CntW'(W - 1));
  assign sq_in    = (dsq_q <= {2'b00, rest_q});
  assign rest_gt1 = (rest_q > W'(1));
  assign acc_gt1  = (acc_q > W'(1));

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          state_d = (number_i > W'(1)) ? ST_CHECK : ST_DONE;
        end
      end
      ST_CHECK: begin
        if (sq_in) begin
          state_d = ST_DIV_REST;
        end else if (rest_gt1) begin
          state_d = ST_DIV_LEFT;
        end else begin
          state_d = ST_STEP;
        end
      end
      ST_DIV_REST: begin
        if (div_last) begin
          if (rem_nx != '0) begin
            state_d = ST_CHECK;
          end else if (!found_q) begin
            state_d = ST_DIV_ACC;
          end
        end
      end
      ST_DIV_ACC: begin
        if (div_last) begin
          state_d = ST_DIV_REST;
        end
      end
      ST_DIV_LEFT: begin
        if (div_last) begin
          state_d = ST_STEP;
        end
      end
      ST_STEP: begin
        state_d = acc_gt1 ? ST_CHECK : ST_DONE;
      end
      ST_DONE: begin
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    acc_d   = acc_q;
    rest_d  = rest_q;
    dv_d    = dv_q;
    dsq_d   = dsq_q;
    found_d = found_q;
    first_d = first_q;
    tot_d   = tot_q;
    depth_d = depth_q;
    rem_d   = rem_q;
    quo_d   = quo_q;
    dvs_d   = dvs_q;
    cnt_d   = cnt_q;
    unique case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          acc_d   = number_i;
          rest_d  = number_i;
          dv_d    = W'(2);
          dsq_d   = SqW'(4);
          found_d = 1'b0;
          first_d = 1'b1;
          tot_d   = number_i;
          depth_d = '0;
        end
      end
      ST_CHECK: begin
        rem_d = '0;
        cnt_d = '0;
        if (sq_in) begin
          quo_d = rest_q;
          dvs_d = dv_q;
        end else begin
          quo_d = acc_q;
          dvs_d = rest_q;
        end
      end
      ST_DIV_REST: begin
        rem_d = rem_nx;
        quo_d = quo_nx;
        cnt_d = cnt_q + CntW'(1);
        if (div_last) begin
          rem_d = '0;
          cnt_d = '0;
          if (rem_nx != '0) begin
            dsq_d   = dsq_q + {1'b0, dv_q, 1'b1};
            dv_d    = dv_q + W'(1);
            found_d = 1'b0;
          end else begin
            rest_d = quo_nx;
            if (!found_q) begin
              quo_d   = acc_q;
              found_d = 1'b1;
            end
          end
        end
      end
      ST_DIV_ACC: begin
        rem_d = rem_nx;
        quo_d = quo_nx;
        cnt_d = cnt_q + CntW'(1);
        if (div_last) begin
          acc_d = acc_q - quo_nx;
          rem_d = '0;
          cnt_d = '0;
          quo_d = rest_q;
        end
      end
      ST_DIV_LEFT: begin
        rem_d = rem_nx;
        quo_d = quo_nx;
        cnt_d = cnt_q + CntW'(1);
        if (div_last) begin
          acc_d = acc_q - quo_nx;
        end
      end
      ST_STEP: begin
        first_d = 1'b0;
        if (first_q) begin
          tot_d = acc_q;
        end
        if (depth_q != DepthMax) begin
          depth_d = depth_q + DepthWidth'(1);
        end
        rest_d  = acc_q;
        dv_d    = W'(2);
        dsq_d   = SqW'(4);
        found_d = 1'b0;
      end
      ST_DONE: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q   <= acc_d;
    rest_q  <= rest_d;
    dv_q    <= dv_d;
    dsq_q   <= dsq_d;
    found_q <= found_d;
    first_q <= first_d;
    tot_q   <= tot_d;
    depth_q <= depth_d;
    rem_q   <= rem_d;
    quo_q   <= quo_d;
    dvs_q   <= dvs_d;
    cnt_q   <= cnt_d;
  end

  assign busy_o        = (state_q != ST_IDLE);
  assign done_o        = (state_q == ST_DONE);
  assign totient_o     = tot_q;
  assign chain_depth_o = depth_q;

  a_div_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV_REST || state_q == ST_DIV_ACC || state_q == ST_DIV_LEFT)
      |-> (dvs_q != '0))
    else $error("divider runs with a zero divisor");

  a_take_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> busy_o)
    else $error("accepted word did not make the block busy");

  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o && !busy_o)
    else $error("result strobe longer than one cycle");

  a_step_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_STEP) |-> (acc_q != '0))
    else $error("totient of a number above one came out zero");

endmodule

`default_nettype wire

FILE: tb/tcd_checker.sv
module tcd_checker
  import tcd_pkg::*;
#(
  parameter int unsigned NUMBER_WIDTH = NumberWidthDef
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    start_i,
  input  wire logic                    busy_i,
  input  wire logic [NUMBER_WIDTH-1:0] number_i,
  input  wire logic                    done_i,
  input  wire logic [NUMBER_WIDTH-1:0] totient_i,
  input  wire logic [DepthWidth-1:0]   chain_depth_i,
  output int unsigned                  mismatches_o,
  output int unsigned                  outstanding_o,
  output int unsigned                  checked_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned MaxReports = 10;

  typedef struct packed {
    logic [NUMBER_WIDTH-1:0] totient;
    logic [DepthWidth-1:0]   depth;
  } totient_word_t;

  totient_word_t due_words[$];
  int unsigned   mismatches = 0;
  int unsigned   checked = 0;

  assign mismatches_o  = mismatches;
  assign checked_o     = checked;

  function automatic longint unsigned euler_phi(input longint unsigned n);
    longint unsigned acc;
    longint unsigned rest;
    longint unsigned d;
    if (n == 0) return 0;
    acc  = n;
    rest = n;
    for (d = 2; d * d <= rest; d++) begin
      if (rest % d == 0) begin
        acc -= acc / d;
        while (rest % d == 0) rest /= d;
      end
    end
    if (rest > 1) acc -= acc / rest;
    return acc;
  endfunction

  function automatic totient_word_t predict_word(input logic [NUMBER_WIDTH-1:0] number);
    totient_word_t   word;
    longint unsigned value;
    int unsigned     steps;
    value = number;
    steps = 0;
    word  = '0;
    if (value == 0) return word;
    word.totient = NUMBER_WIDTH'(euler_phi(value));
    while (value > 1) begin
      value = euler_phi(value);
      steps++;
    end
    word.depth = (steps > DepthMax) ? DepthMax : DepthWidth'(steps);
    return word;
  endfunction

  task automatic check_field(input string field, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      if (mismatches < MaxReports) begin
        $display("Result %0d: %s expected %0d, got %0d.", checked, field, want, got);
      end
      mismatches++;
    end
  endtask

  always @(posedge clk_i) begin
    totient_word_t want;
    if (rst_ni) begin
      if (done_i) begin
        if (due_words.size() == 0) begin
          if (mismatches < MaxReports) begin
            $display("Result with no word pending: totient %0d, depth %0d.",
                     totient_i, chain_depth_i);
          end
          mismatches++;
        end else begin
          want = due_words.pop_front();
          checked++;
          check_field("totient", 32'(want.totient), 32'(totient_i));
          check_field("chain depth", 32'(want.depth), 32'(chain_depth_i));
        end
      end
      if (start_i && !busy_i) begin
        due_words = {due_words, predict_word(number_i)};
      end
    end
    outstanding_o = due_words.size();
  end

endmodule

FILE: tb/tb_totient_and_chain_depth_top.sv
module tb_totient_and_chain_depth_top;
  timeunit 1ns;
  timeprecision 1ps;

  import tcd_pkg::*;

  localparam int unsigned NumW          = NumberWidthDef;
  localparam int unsigned RandomWords   = 100;
  localparam int unsigned WatchdogLimit = 1_000_000;
  localparam int unsigned TailCycles    = 64;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  start = 1'b0;
  logic [NumW-1:0]       number = '0;
  logic                  busy;
  logic                  done;
  logic [NumW-1:0]       totient;
  logic [DepthWidth-1:0] chain_depth;

  int unsigned mismatches;
  int unsigned outstanding;
  int unsigned checked;
  int unsigned words_sent = 0;
  int unsigned burst_left = 0;
  int unsigned idle_cycles = 0;

  totient_and_chain_depth_top #(
    .NUMBER_WIDTH(NumW)
  ) dut (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .start_i      (start),
    .busy_o       (busy),
    .number_i     (number),
    .done_o       (done),
    .totient_o    (totient),
    .chain_depth_o(chain_depth)
  );

  tcd_checker #(
    .NUMBER_WIDTH(NumW)
  ) checker_i (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .start_i      (start),
    .busy_i       (busy),
    .number_i     (number),
    .done_i       (done),
    .totient_i    (totient),
    .chain_depth_i(chain_depth),
    .mismatches_o (mismatches),
    .outstanding_o(outstanding),
    .checked_o    (checked)
  );

  initial forever #10 clk = ~clk;

  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || done) begin
      idle_cycles <= 0;
    end else if (idle_cycles + 1 >= WatchdogLimit) begin
      $display("Watchdog: no word moved in %0d cycles.", WatchdogLimit);
      $display("== FAIL ==");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 50) return $urandom_range(1, 3);
    if (roll < 85) return $urandom_range(4, 60);
    return $urandom_range(100, 2000);
  endfunction

  task automatic send_word(input logic [NumW-1:0] value);
    int unsigned gap;
    start  <= 1'b1;
    number <= value;
    do @(posedge clk); while (busy);
    words_sent++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 6);
      gap = pick_gap();
      start <= 1'b0;
      repeat (gap) begin
        number <= NumW'($urandom);
        @(posedge clk);
      end
    end
  endtask

  initial begin
    int unsigned     directed[] = '{0, 1, 2, 3, 4, 6, 7, 9, 12, 30, 97, 1024, 2097151,
                                    1048576, 2097143, 1594323, 2097142, 1};
    int unsigned     roll;
    logic [NumW-1:0] value;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    foreach (directed[i]) send_word(NumW'(directed[i]));
    repeat (RandomWords) begin
      roll = $urandom_range(0, 99);
      if (roll < 3) begin
        value = NumW'($urandom_range(0, 1));
      end else if (roll < 6) begin
        value = NumW'($urandom);
      end else if (roll < 22) begin
        value = NumW'($urandom_range(1024, 16383));
      end else begin
        value = NumW'($urandom_range(2, 1023));
      end
      send_word(value);
    end
    start <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (TailCycles) @(posedge clk);
    $display("Sent %0d words (%0d directed, the rest random with bursts and gaps);",
             words_sent, directed.size());
    $display("%0d results checked.", checked);
    if (mismatches == 0 && outstanding == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
